>>> hw/rtl/sust_pkg.sv
// ----------------------------------------------------------------------------
// sust_pkg
// Shared types and constants for the sorted unique set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sust_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  // Operation codes carried in the func field.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } sust_status_t;

  typedef enum logic {
    SM_IDLE,
    SM_UPDATE
  } sust_state_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;   // latch the compare flags against the key
    logic ins;   // shift up from the boundary and drop the key in
    logic rem;   // shift down from the matching entry
  } sust_cell_ctrl_t;

endpackage

>>> hw/rtl/sust_if.sv
// ----------------------------------------------------------------------------
// sust_req_if / sust_rsp_if
// Valid/ready channels for the operation requests and their results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sust_req_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [sust_pkg::VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sust_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sust_pkg::STATUS_W-1:0] status;
  logic [sust_pkg::POS_W-1:0]    position;
  logic [sust_pkg::POS_W-1:0]    new_count;

  modport source (output valid, output status, output position, output new_count,
                  input ready);
  modport sink   (input valid, input status, input position, input new_count,
                  output ready);
endinterface

>>> hw/rtl/sust_cell.sv
// ----------------------------------------------------------------------------
// sust_cell
// One slot of the sorted chain: holds an entry, compares it with the key and
// takes its neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sust_cell (
  input  logic                                clk,
  input  sust_pkg::sust_cell_ctrl_t           ctrl,
  input  logic                                occupied,
  input  logic signed [sust_pkg::VALUE_W-1:0] key,
  input  logic                                left_lt,
  input  logic signed [sust_pkg::VALUE_W-1:0] left_entry,
  input  logic signed [sust_pkg::VALUE_W-1:0] right_entry,
  output logic signed [sust_pkg::VALUE_W-1:0] entry,
  output logic                                lt,
  output logic                                eq
);
  import sust_pkg::*;

  logic signed [VALUE_W-1:0] entry_next;

  // Cells at or above the boundary move; the one right at it takes the key.
  always_comb begin
    entry_next = entry;
    if (ctrl.ins && !lt) begin
      entry_next = left_lt ? key : left_entry;
    end else if (ctrl.rem && !lt) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.cmp) begin
      lt <= occupied && (entry < key);
      eq <= occupied && (entry == key);
    end
  end

endmodule

>>> hw/rtl/sorted_unique_set_table_core.sv
// A result is registered in the update state that follows its request transfer,
// which is held while an older result is still waiting to be taken.
// A new request is taken only in idle, after the previous one has left the update
// state; the compare and the shift of the cell chain both use the stored entries.
// Reset (synchronous, active high) empties the table and drops any pending
// result; the stored values themselves are not cleared.
// ----------------------------------------------------------------------------
// sorted_unique_set_table_core
// Keeps a set of distinct signed values in ascending order in a chain of
// compare-and-shift cells, with insert and remove operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_unique_set_table_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  sust_req_if.sink          req,
  sust_rsp_if.source        rsp
);
  import sust_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Control state.
  sust_state_t     state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             rsp_valid, rsp_valid_next;

  // Request held during the update cycle.
  logic                      func_q;
  logic signed [VALUE_W-1:0] value_q;

  // Result register.
  sust_status_t     status_q;
  logic [POS_W-1:0] position_q;
  logic [POS_W-1:0] new_count_q;

  // Chain wiring.
  sust_cell_ctrl_t            ctrl;
  logic signed [VALUE_W-1:0]  key;
  logic signed [VALUE_W-1:0]  entry_v [DEPTH];
  logic [DEPTH-1:0]           lt_v;
  logic [DEPTH-1:0]           eq_v;
  logic [DEPTH-1:0]           occ_v;
  logic [DEPTH+1:0]           lt_ext;

  logic             req_fire;
  logic             upd_fire;
  logic             present;
  logic             full;
  logic [CNT_W-1:0] pos;
  sust_status_t     status_c;
  logic [CNT_W-1:0] count_upd;
  logic [POS_W-1:0] pos_out;
  logic [POS_W-1:0] cnt_out;

  // ---------------------------------------------------------------------------
  // Sequencer. In idle the block takes a request and every cell latches its
  // compare flags against the new value. The update cycle then resolves the
  // position and the status, shifts the chain and loads the result register,
  // waiting there only while an older result has not been taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      SM_IDLE:   if (req.valid) state_next = SM_UPDATE;
      SM_UPDATE: if (!rsp_valid || rsp.ready) state_next = SM_IDLE;
      default:   state_next = SM_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    upd_fire  = 1'b0;
    case (state)
      SM_IDLE:   req.ready = 1'b1;
      SM_UPDATE: upd_fire  = !rsp_valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
        upd_fire  = 1'b0;
      end
    endcase
  end

  assign req_fire = req.valid && req.ready;

  // The compare needs the incoming value; the insert needs the held one.
  assign key = (state == SM_IDLE) ? req.value : value_q;

  // ---------------------------------------------------------------------------
  // Cell chain. A cell is occupied when its index is below the count. The
  // extended flag vector adds a virtual "smaller" cell on the left and a
  // virtual "not smaller" cell on the right, so that exactly one boundary
  // exists: the first cell whose entry is not below the key.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      left_lt;
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    assign occ_v[i] = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_entry = key;
    end else begin : g_inner_l
      assign left_lt    = lt_v[i-1];
      assign left_entry = entry_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = entry_v[i];
    end else begin : g_inner_r
      assign right_entry = entry_v[i+1];
    end

    sust_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ_v[i]),
      .key         (key),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_v[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  assign lt_ext = {1'b0, lt_v, 1'b1};

  // The boundary is one-hot over DEPTH+1 places; encode it to the position.
  always_comb begin
    pos = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (lt_ext[i] && !lt_ext[i+1]) pos = pos | CNT_W'(i);
    end
  end

  // Entries are distinct, so at most one cell can match.
  assign present = |eq_v;
  assign full    = (count == CNT_W'(DEPTH));

  // Duplicates are checked before fullness.
  always_comb begin
    status_c  = ST_NOT_FOUND;
    count_upd = count;
    ctrl.cmp  = req_fire;
    ctrl.ins  = 1'b0;
    ctrl.rem  = 1'b0;
    if (func_q == FUNC_INSERT) begin
      if (present) begin
        status_c = ST_DUPLICATE;
      end else if (full) begin
        status_c = ST_FULL;
      end else begin
        status_c  = ST_INSERTED;
        count_upd = count + 1'b1;
        ctrl.ins  = upd_fire;
      end
    end else begin
      if (present) begin
        status_c  = ST_REMOVED;
        count_upd = count - 1'b1;
        ctrl.rem  = upd_fire;
      end else begin
        status_c = ST_NOT_FOUND;
      end
    end
  end

  assign count_next     = upd_fire ? count_upd : count;
  assign rsp_valid_next = upd_fire ? 1'b1 : (rsp_valid && !rsp.ready);

  // Position and count are reported modulo the width of the result fields.
  for (genvar b = 0; b < POS_W; b++) begin : g_resize
    if (b < CNT_W) begin : g_bit
      assign pos_out[b] = pos[b];
      assign cnt_out[b] = count_upd[b];
    end else begin : g_zero
      assign pos_out[b] = 1'b0;
      assign cnt_out[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SM_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      func_q  <= req.func;
      value_q <= req.value;
    end
    if (upd_fire) begin
      status_q    <= status_c;
      position_q  <= pos_out;
      new_count_q <= cnt_out;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status_q;
  assign rsp.position  = position_q;
  assign rsp.new_count = new_count_q;

endmodule

>>> hw/rtl/sust_chk.sv
// ----------------------------------------------------------------------------
// sust_chk
// Port-level checks for the sorted unique set table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sust_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sust_pkg::STATUS_W-1:0] status,
  input logic [sust_pkg::POS_W-1:0]    position
);
  import sust_pkg::*;

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result offered right after reset");

  // A request transfer is followed by the update cycle, which takes no request.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken during the update cycle");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_INSERTED || status == ST_DUPLICATE ||
                   status == ST_REMOVED || status == ST_NOT_FOUND ||
                   status == ST_FULL))
    else $error("undefined status code");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(position)))
    else $error("stalled result changed");

endmodule

bind sorted_unique_set_table_core sust_chk u_sust_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .position  (rsp.position)
);

>>> tb/sorted_unique_set_table_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_table_core_tb
// Self-checking bench for the sorted unique set table. A shadow copy of the
// ordered table predicts the status, position and new count of every
// operation, and each result transfer is compared against the oldest
// prediction. Directed operations cover the edges of the table, and random
// operations from small value pools drive it through fill and drain cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_unique_set_table_core_tb;

  import sust_pkg::*;

  localparam int TABLE_DEPTH      = 16;
  localparam int RAND_PHASES      = 10;
  localparam int PHASE_OPS        = 122;
  localparam int POOL_SIZE        = 24;
  localparam int HOLD_PHASE       = 3;
  localparam int SINK_HOLD_CYCLES = 300;
  // The quietest legal stretch is the long receiver hold-off; allow a wide
  // margin above it before declaring the block hung.
  localparam int QUIET_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 10;

  // One predicted result of an insert or remove.
  typedef struct {
    sust_status_t         status;
    logic [POS_W-1:0]     position;
    logic [POS_W-1:0]     new_count;
  } set_outcome_t;

  // Shadow of the ordered table. Every accepted operation is applied here at
  // once, and its outcome is queued until the matching result transfer.
  class set_table_tracker;
    logic signed [VALUE_W-1:0] vals [TABLE_DEPTH];
    int unsigned               fill;
    set_outcome_t              due_outcomes [$];
    int                        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return due_outcomes.size();
    endfunction

    function void apply_op(logic op, logic signed [VALUE_W-1:0] v);
      int unsigned  pos;
      int unsigned  k;
      bit           hit;
      set_outcome_t res;
      pos = 0;
      while (pos < fill && vals[pos] < v) pos++;
      hit = (pos < fill) && (vals[pos] == v);
      if (op == FUNC_INSERT) begin
        if (hit) begin
          res.status = ST_DUPLICATE;
        end else if (fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = fill; k > pos; k--) vals[k] = vals[k - 1];
          vals[pos] = v;
          fill++;
          res.status = ST_INSERTED;
        end
      end else begin
        if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (k = pos; k + 1 < fill; k++) vals[k] = vals[k + 1];
          fill--;
          res.status = ST_REMOVED;
        end
      end
      res.position  = pos[POS_W-1:0];
      res.new_count = fill[POS_W-1:0];
      due_outcomes.push_back(res);
    endfunction

    function void check_outcome(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
                                logic [POS_W-1:0] cnt);
      set_outcome_t want;
      if (due_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status=%0d position=%0d new_count=%0d",
                 $time, st, pos, cnt);
        return;
      end
      want = due_outcomes.pop_front();
      if (st !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, st);
      end
      if (pos !== want.position) begin
        errors++;
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, pos);
      end
      if (cnt !== want.new_count) begin
        errors++;
        $display("%0t: new_count mismatch, expected %0d, actual %0d",
                 $time, want.new_count, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Random idling on both channels is on while this is set; the long
  // receiver hold-off is requested through the second flag.
  bit idle_on       = 1'b1;
  bit sink_hold_req = 1'b0;

  set_table_tracker tracker = new();

  sust_req_if req_ch ();
  sust_rsp_if rsp_ch ();

  sorted_unique_set_table_core #(
    .DEPTH (TABLE_DEPTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Values that sit at the signed extremes, plus bit patterns that make
  // every bit of the value field take both levels early on.
  logic signed [VALUE_W-1:0] fill_vals [14] = '{
    32'sh8000_0000, -32'sd1, 32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
    32'sh8000_0001, 32'sh7FFF_FFFE, -32'sd100, 32'sd100, 32'sd2, -32'sd2,
    32'sh1234_5678, 32'shEDCB_A987, 32'sh00FF_00FF
  };

  // Offer one operation and hold it until the block takes it. The caller
  // is always sitting on a rising edge when this starts, so valid is
  // raised (or kept high) with a single nonblocking update.
  task automatic drive_op(input logic op, input logic signed [VALUE_W-1:0] v);
    req_ch.valid <= 1'b1;
    req_ch.func  <= op;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    tracker.apply_op(op, v);
  endtask

  // Occasionally, while idling is on, drop valid for a random burst.
  task automatic source_gap();
    if (idle_on && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Lower valid and wait until every predicted result has been seen.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Receiver: ready is normally high, drops in short random bursts, and
  // once in the run stays low for a long stretch so that the block backs
  // up and has to refuse new requests.
  initial begin : result_sink
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_outcome(rsp_ch.status, rsp_ch.position, rsp_ch.new_count);
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too
  // many cycles in a row.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [VALUE_W-1:0] pool [POOL_SIZE];
    logic signed [VALUE_W-1:0] v;
    logic                      op;
    int                        ins_pct;

    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_INSERT;
    req_ch.value = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Start with a remove on the empty table, then place
    // both signed extremes and zero, and exercise a duplicate insert and a
    // remove of a value that was never stored.
    drive_op(FUNC_REMOVE, 32'sd0);
    drive_op(FUNC_INSERT, 32'sh8000_0000);
    drive_op(FUNC_INSERT, 32'sh7FFF_FFFF);
    drive_op(FUNC_INSERT, 32'sd0);
    drive_op(FUNC_INSERT, 32'sh7FFF_FFFF);
    drive_op(FUNC_REMOVE, 32'sd7);
    drive_op(FUNC_REMOVE, 32'sh8000_0000);
    // Two entries remain, so these fourteen inserts fill the table exactly.
    foreach (fill_vals[i]) begin
      drive_op(FUNC_INSERT, fill_vals[i]);
      source_gap();
    end
    // With the table full, a new value is refused, while a value already
    // stored still reports as a duplicate because presence wins over space.
    drive_op(FUNC_INSERT, 32'sd3);
    drive_op(FUNC_INSERT, 32'sd1);
    // Removing from the middle shifts the upper entries down; the freed slot
    // is then reused. Then the last and the first entries go.
    drive_op(FUNC_REMOVE, 32'sd1);
    drive_op(FUNC_INSERT, 32'sd3);
    drive_op(FUNC_REMOVE, 32'sh7FFF_FFFF);
    drive_op(FUNC_REMOVE, 32'sh8000_0000);
    drive_op(FUNC_REMOVE, 32'sd1);
    drain_results();

    // Random part. Each phase draws most values from a small pool so that
    // duplicates, hits and a full table are common; phases alternate
    // between insert-heavy (fills the table) and remove-heavy (drains it).
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph != RAND_PHASES - 1) && (ph % 3 != 2);
      ins_pct = (ph % 2 == 0) ? 70 : 35;
      foreach (pool[i]) begin
        case ($urandom_range(0, 3))
          0:       pool[i] = int'($urandom_range(0, 40)) - 20;
          1: begin
            case ($urandom_range(0, 5))
              0:       pool[i] = 32'sh8000_0000;
              1:       pool[i] = 32'sh8000_0001;
              2:       pool[i] = 32'sh7FFF_FFFE;
              3:       pool[i] = 32'sh7FFF_FFFF;
              4:       pool[i] = -32'sd1;
              default: pool[i] = 32'sd0;
            endcase
          end
          default: pool[i] = $urandom;
        endcase
      end
      // In one phase the receiver stops for a long stretch while the
      // sender keeps offering back to back.
      if (ph == HOLD_PHASE) begin
        idle_on       = 1'b0;
        sink_hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_OPS; n++) begin
        op = ($urandom_range(1, 100) <= ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
        if ($urandom_range(0, 6) == 0) begin
          v = $urandom;
        end else begin
          v = pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        drive_op(op, v);
        source_gap();
      end
      // The sender pauses at each phase boundary until every result is in.
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sust_pkg.sv
hw/rtl/sust_if.sv
hw/rtl/sust_cell.sv
hw/rtl/sorted_unique_set_table_core.sv
hw/rtl/sust_chk.sv
tb/sorted_unique_set_table_core_tb.sv
